// ===== src/rfwf_pkg.sv =====
// ----------------------------------------------------------------------------
// rfwf_pkg: shared types and constants of the rightmost free window finder
// Item and result structs, opcodes, controller states and ring control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rfwf_pkg;

    localparam int MAX_POSITIONS_DEF = 1024;
    localparam int FIELD_W           = 11;
    localparam logic [FIELD_W-1:0] LINE_LEN_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_QUERY = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FIELD_W-1:0] seg_start;
        logic [FIELD_W-1:0] seg_end;
        logic [FIELD_W-1:0] window_len;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] window_start;
        logic [FIELD_W-1:0] window_end;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic wbit;
    } t_ring_ctl;

endpackage

`default_nettype wire

// ===== src/rfwf_cell.sv =====
// ----------------------------------------------------------------------------
// rfwf_cell: one occupancy bit of the position ring
// Holds one bit and takes its neighbor's bit whenever the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module rfwf_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  rfwf_pkg::t_ring_ctl  i_ctl,
    input  wire                  i_d,
    output logic                 o_q
);
    import rfwf_pkg::*;

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.shift) begin
            r_bit <= i_d;
        end
    end

    assign o_q = r_bit;

endmodule

`default_nettype wire

// ===== src/rfwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfwf_ctrl: sequencer for the position ring
// Rotates the ring once per clear, mark or query item, rewrites the head bit and tracks free runs.
// ----------------------------------------------------------------------------
`default_nettype none

module rfwf_ctrl #(
    parameter int MAX_POSITIONS = rfwf_pkg::MAX_POSITIONS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  rfwf_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output rfwf_pkg::t_out_item           o_out_data,
    input  wire [rfwf_pkg::FIELD_W-1:0]   i_line_length,
    input  wire                           i_head,
    output rfwf_pkg::t_ring_ctl           o_ring
);
    import rfwf_pkg::*;

    localparam int PW = $clog2(MAX_POSITIONS + 1);
    localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_pos, n_pos;
    logic [PW-1:0]      r_run, n_run;
    logic [1:0]         r_op;
    logic [FIELD_W-1:0] r_lo, r_hi, r_k;
    logic               r_found, n_found;
    logic [FIELD_W-1:0] r_ws, n_ws, r_we, n_we;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               w_accept;
    logic               w_load;
    logic [CW-1:0]      w_pos_x, w_line_x, w_max_x, w_m_eff;
    logic [CW-1:0]      w_run_inc_x, w_k_x, w_lo_x, w_hi_x;
    logic [CW:0]        w_end_x;
    logic [PW-1:0]      w_run_inc;
    logic               w_in_line, w_free, w_hit, w_in_seg;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // datapath at the ring head
    always_comb begin
        w_pos_x     = CW'(r_pos);
        w_line_x    = CW'(i_line_length);
        w_max_x     = CW'(MAX_POSITIONS);
        w_m_eff     = (w_line_x > w_max_x) ? w_max_x : w_line_x;
        w_in_line   = (w_pos_x <= w_m_eff);
        w_free      = !i_head;
        w_run_inc   = r_run + PW'(1);
        w_run_inc_x = CW'(w_run_inc);
        w_k_x       = CW'(r_k);
        w_lo_x      = CW'(r_lo);
        w_hi_x      = CW'(r_hi);
        w_in_seg    = (w_lo_x <= w_pos_x) && (w_pos_x <= w_hi_x);
        w_hit       = (r_op == OP_QUERY) && w_in_line && w_free && !r_found
                      && (w_run_inc_x == w_k_x);
        w_end_x     = {1'b0, w_pos_x} + {1'b0, w_k_x} - (CW + 1)'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in_data.opcode == OP_CLEAR
                                 || i_in_data.opcode == OP_MARK
                                 || i_in_data.opcode == OP_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_pos == PW'(1)) begin
                    n_state = (r_op == OP_QUERY) ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and scan bookkeeping
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_ring      = '0;
        n_pos       = r_pos;
        n_run       = r_run;
        n_found     = r_found;
        n_ws        = r_ws;
        n_we        = r_we;
        unique case (r_state)
            ST_IDLE: begin
                n_pos   = PW'(MAX_POSITIONS);
                n_run   = '0;
                n_found = 1'b0;
                n_ws    = '0;
                n_we    = '0;
            end
            ST_SCAN: begin
                o_ring.shift = 1'b1;
                priority case (r_op)
                    OP_CLEAR: o_ring.wbit = 1'b0;
                    OP_MARK:  o_ring.wbit = i_head | w_in_seg;
                    default:  o_ring.wbit = i_head;
                endcase
                n_pos = r_pos - PW'(1);
                n_run = (w_in_line && w_free) ? w_run_inc : '0;
                if (w_hit) begin
                    n_found = 1'b1;
                    n_ws    = w_pos_x[FIELD_W-1:0];
                    n_we    = w_end_x[FIELD_W-1:0];
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_run <= n_run;
        r_ws  <= n_ws;
        r_we  <= n_we;
        if (w_accept) begin
            r_op <= i_in_data.opcode;
            r_lo <= i_in_data.seg_start;
            r_hi <= i_in_data.seg_end;
            r_k  <= i_in_data.window_len;
        end
        if (w_load) begin
            r_out_data.found        <= r_found;
            r_out_data.window_start <= r_ws;
            r_out_data.window_end   <= r_we;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_scan_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_pos != '0))
        else $error("scan position reached zero");

    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.opcode == OP_QUERY)
        |=> (r_state == ST_SCAN && r_pos == PW'(MAX_POSITIONS)))
        else $error("query did not start a full scan");

    a_found_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_found) |-> (r_ws != '0 && r_we >= r_ws))
        else $error("found window has bad bounds");

    a_miss_zero_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found)
        |-> (o_out_data.window_start == '0 && o_out_data.window_end == '0))
        else $error("missed query reports nonzero window");

    a_result_only_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared without a completed scan");

endmodule

`default_nettype wire

// ===== src/rightmost_free_window_finder.sv =====
// A query result is loaded into the output register in ST_DONE after the full scan,
// once that register is free or its result is being taken. A new item is accepted only in ST_IDLE;
//   each clear, mark or query rotates the occupancy ring of MAX_POSITIONS cells once, one cell a cycle.
// Opcode 3 is dropped in the accept cycle and gives no result.
// Reset: synchronous, active low; map all free, line_length 1024, no result pending.
// ----------------------------------------------------------------------------
// rightmost_free_window_finder: top level
// Occupancy ring of bit cells plus a sequencer that marks, clears and finds the
// rightmost run of free positions of a requested length.
// ----------------------------------------------------------------------------
`default_nettype none

module rightmost_free_window_finder #(
    parameter int MAX_POSITIONS = rfwf_pkg::MAX_POSITIONS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  rfwf_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output rfwf_pkg::t_out_item           o_out_data,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [rfwf_pkg::FIELD_W-1:0]   i_cfg_data
);
    import rfwf_pkg::*;

    logic [FIELD_W-1:0]       r_line_length;
    t_ring_ctl                w_ring;
    logic [MAX_POSITIONS-1:0] w_q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_length <= i_cfg_data;
        end
    end

    // cell i holds position i+1 at rest; the last cell is the head
    for (genvar gi = 0; gi < MAX_POSITIONS; gi++) begin : g_ring
        if (gi == 0) begin : g_first
            rfwf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ring),
                .i_d     (w_ring.wbit),
                .o_q     (w_q[gi])
            );
        end else begin : g_rest
            rfwf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ring),
                .i_d     (w_q[gi-1]),
                .o_q     (w_q[gi])
            );
        end
    end

    rfwf_ctrl #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .i_line_length (r_line_length),
        .i_head        (w_q[MAX_POSITIONS-1]),
        .o_ring        (w_ring)
    );

endmodule

`default_nettype wire

// ===== tb/rfwf_window_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfwf_window_checker: prediction and comparison for the window finder
// Watches the item, result and line length channels. Keeps its own occupancy
// map and line length, works out the window each query should return and
// compares every result beat with the oldest waiting prediction.
// ----------------------------------------------------------------------------
module rfwf_window_checker #(
    parameter int MAX_POS = rfwf_pkg::MAX_POSITIONS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    input  wire                           i_in_ready,
    input  rfwf_pkg::t_in_item            i_in_data,
    input  wire                           i_out_valid,
    input  wire                           i_out_ready,
    input  rfwf_pkg::t_out_item           i_out_data,
    input  wire                           i_cfg_valid,
    input  wire                           i_cfg_ready,
    input  wire [rfwf_pkg::FIELD_W-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import rfwf_pkg::*;

    bit [MAX_POS:0]     occ_map;
    logic [FIELD_W-1:0] line_len;
    t_out_item          expected_windows[$];
    int                 fail_count;

    function automatic void mark_span(input int unsigned lo, input int unsigned hi);
        if (lo > hi) return;
        if (lo < 1) lo = 1;
        // positions past the map are dropped
        if (hi > MAX_POS) hi = MAX_POS;
        for (int unsigned p = lo; p <= hi; p++) occ_map[p] = 1'b1;
    endfunction

    function automatic t_out_item find_rightmost_window(input int unsigned k);
        t_out_item   win;
        int unsigned span;
        int unsigned run;
        win  = '0;
        run  = 0;
        span = (line_len > MAX_POS) ? MAX_POS : line_len;
        if (k == 0 || k > span) return win;
        for (int p = span; p >= 1; p--) begin
            if (occ_map[p]) begin
                run = 0;
            end else begin
                run++;
                if (run == k) begin
                    win.found        = 1'b1;
                    win.window_start = FIELD_W'(p);
                    win.window_end   = FIELD_W'(p + k - 1);
                    return win;
                end
            end
        end
        return win;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            occ_map  = '0;
            line_len = LINE_LEN_RESET;
            expected_windows.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_windows.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat: found %0d start %0d end %0d",
                             $time, i_out_data.found, i_out_data.window_start,
                             i_out_data.window_end);
                end else begin
                    want = expected_windows.pop_front();
                    if (i_out_data.found !== want.found) begin
                        fail_count++;
                        $display("%0t: found mismatch, expected %0d, got %0d",
                                 $time, want.found, i_out_data.found);
                    end
                    if (i_out_data.window_start !== want.window_start) begin
                        fail_count++;
                        $display("%0t: window_start mismatch, expected %0d, got %0d",
                                 $time, want.window_start, i_out_data.window_start);
                    end
                    if (i_out_data.window_end !== want.window_end) begin
                        fail_count++;
                        $display("%0t: window_end mismatch, expected %0d, got %0d",
                                 $time, want.window_end, i_out_data.window_end);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) line_len = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.opcode)
                    OP_CLEAR: begin
                        occ_map = '0;
                    end
                    OP_MARK: begin
                        mark_span(i_in_data.seg_start, i_in_data.seg_end);
                    end
                    OP_QUERY: begin
                        want = find_rightmost_window(i_in_data.window_len);
                        expected_windows.insert(expected_windows.size(), want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_windows.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: rightmost free window finder
// Drives a directed opening and then blocks of random clear, mark, query and
// unused-opcode beats under several line lengths and idling patterns, with one
// long output hold-off, and reports the verdict of the window checker.
// ----------------------------------------------------------------------------
module testbench;
    import rfwf_pkg::*;

    localparam int         MAX_POS        = MAX_POSITIONS_DEF;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         HOLD_CYCLES    = 6000;
    localparam int         WATCHDOG_LIMIT = 40000;
    localparam int         NUM_BLOCKS     = 10;
    localparam int         BLOCK_ITEMS    = 56;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_data   = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [FIELD_W-1:0] cfg_data  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_cfg_ready;
    t_out_item          o_out_data;

    int   fail_count;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_go     = 1'b0;
    logic hold_taken  = 1'b0;
    int   hold_left   = 0;
    int   quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rightmost_free_window_finder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    rfwf_window_checker #(.MAX_POS(MAX_POS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] op, input int s, input int e,
                                           input int k);
        t_in_item it;
        it.opcode     = op;
        it.seg_start  = FIELD_W'(s);
        it.seg_end    = FIELD_W'(e);
        it.window_len = FIELD_W'(k);
        return it;
    endfunction

    function automatic t_in_item noise_item();
        return make_item(2'($urandom_range(3)), $urandom_range(2047), $urandom_range(2047),
                         $urandom_range(2047));
    endfunction

    function automatic t_in_item window_query(input int lim);
        t_in_item it;
        int       pick;
        it        = noise_item();
        it.opcode = OP_QUERY;
        pick      = $urandom_range(9);
        if (pick < 2) begin
            it.window_len = FIELD_W'($urandom_range(2047));
        end else if (pick < 6) begin
            it.window_len = FIELD_W'($urandom_range(1, (lim < 16) ? lim : 16));
        end else begin
            it.window_len = FIELD_W'($urandom_range(1, lim));
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic write_line_length(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= FIELD_W'(value);
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait out every result, then let a mark or clear finish
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (MAX_POS + 8) @(posedge clk);
    endtask

    task automatic run_block(input int n_items, input int lim);
        t_in_item it;
        int       pick;
        int       first;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            it   = noise_item();
            if (pick < 8) begin
                it.opcode = OP_CLEAR;
            end else if (pick < 12) begin
                it.opcode = OP_UNUSED;
            end else if (pick < 50) begin
                it.opcode = OP_MARK;
                // mostly segments inside the line, some stray ones
                if ($urandom_range(9) != 0) begin
                    first        = $urandom_range(1, lim);
                    it.seg_start = FIELD_W'(first);
                    it.seg_end   = FIELD_W'(first + $urandom_range(0, lim / 6));
                end
            end else begin
                it = window_query(lim);
            end
            send_item(it);
        end
    endtask

    initial begin
        int len_plan [NUM_BLOCKS];
        int lim;
        len_plan = '{1024, 1, 2047, 0, 37, 1025, 1024, 2, 600, 1023};
        repeat (8) @(posedge clk);
        rst_n       <= 1'b1;
        tx_idle_pct <= 8;
        rx_idle_pct <= 82;
        @(posedge clk);

        // opening at the reset line length
        send_item(make_item(OP_QUERY, 0, 0, 1));
        send_item(make_item(OP_QUERY, 2047, 2047, 1024));
        send_item(make_item(OP_QUERY, 0, 0, 1025));
        send_item(make_item(OP_QUERY, 0, 0, 0));
        send_item(make_item(OP_QUERY, 0, 0, 2047));
        send_item(make_item(OP_MARK, 1, 1, 0));
        send_item(make_item(OP_MARK, 1024, 1024, 2047));
        send_item(make_item(OP_MARK, 0, 0, 0));
        send_item(make_item(OP_MARK, 1500, 2047, 0));
        send_item(make_item(OP_MARK, 600, 500, 0));
        send_item(make_item(OP_UNUSED, 2047, 2047, 2047));
        send_item(make_item(OP_QUERY, 0, 0, 1022));
        send_item(make_item(OP_QUERY, 0, 0, 1023));
        send_item(make_item(OP_MARK, 512, 512, 0));
        send_item(make_item(OP_QUERY, 0, 0, 511));
        send_item(make_item(OP_QUERY, 0, 0, 510));
        send_item(make_item(OP_CLEAR, 2047, 2047, 2047));
        send_item(make_item(OP_QUERY, 0, 0, 1024));
        send_item(make_item(OP_MARK, 0, 2047, 0));
        send_item(make_item(OP_QUERY, 0, 0, 1));
        send_item(make_item(OP_CLEAR, 0, 0, 0));
        send_item(make_item(OP_QUERY, 0, 0, 3));
        drain();

        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (b < 3) begin
                tx_idle_pct <= 8;
                rx_idle_pct <= 82;
            end else if (b < 6) begin
                tx_idle_pct <= 82;
                rx_idle_pct <= 8;
            end else begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            write_line_length(len_plan[b]);
            lim = (len_plan[b] > MAX_POS) ? MAX_POS : len_plan[b];
            if (lim < 1) lim = 1;
            if (b == 6) begin
                // hold results back while queries keep coming
                hold_go <= 1'b1;
                repeat (4) send_item(window_query(lim));
            end
            run_block(BLOCK_ITEMS, lim);
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule
